// ===== rtl/cle_pkg.sv =====
// Shared types and character constants for the escape decoder.
package cle_pkg;

    // Character codes used by the decoder and the text-form builder.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_V   = 8'h76;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NEWLINE  = 3'd1,
        ST_OCT_OVF  = 3'd2,
        ST_HEX_OVF  = 3'd3,
        ST_UNKNOWN  = 3'd4,
        ST_EOF      = 3'd5
    } t_status;

    // Decoder mode.
    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_OCT   = 2'd2,
        MODE_HEX   = 2'd3
    } t_mode;

    // One input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
        logic [7:0] quote_char;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] char_code;
        logic       last_of_char;
        logic       ends_literal;
        logic       newline_returned;
        t_status    status;
    } t_out_item;

    // One finished character, before it is expanded to its text form.
    typedef struct packed {
        logic [7:0] code;
        logic       bare;
        logic       ends;
        logic       nl;
        t_status    status;
    } t_char;

    // All characters that one input item produces, in emission order.
    typedef struct packed {
        t_char      ch1;
        t_char      ch0;
        logic [1:0] count;
    } t_job;

endpackage

// ===== rtl/cle_decode.sv =====
// Escape decoder: mode and digit accumulator, and the characters each byte finishes.
module cle_decode
    import cle_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_take,
    input  t_in_item i_item,
    output t_job     o_job
);

    t_mode       r_mode, n_mode;
    logic [7:0]  r_acc, n_acc;

    logic [7:0]  w_b;
    logic        w_oct_ok;
    logic        w_dig_ok;
    logic [3:0]  w_dig;
    logic [11:0] w_run;
    logic        w_ovf;
    logic        w_named;
    logic [7:0]  w_named_code;
    logic        w_plain_has;
    t_char       w_plain_ch;

    assign w_b = i_item.data_byte;

    // Digit classification for octal and hex runs.
    assign w_oct_ok = (w_b >= CH_ZERO) && (w_b <= CH_SEVEN);

    always_comb begin
        w_dig_ok = 1'b0;
        w_dig    = w_b[3:0];
        if (r_mode == MODE_HEX) begin
            if ((w_b >= CH_ZERO) && (w_b <= CH_NINE)) begin
                w_dig_ok = 1'b1;
            end else if (((w_b >= CH_LO_A) && (w_b <= CH_LO_F)) ||
                         ((w_b >= CH_UP_A) && (w_b <= CH_UP_F))) begin
                w_dig_ok = 1'b1;
                w_dig    = w_b[3:0] + 4'd9;
            end
        end else begin
            w_dig_ok = w_oct_ok;
        end
    end

    // Accumulated run value; times 16 or 8 is a plain shift.
    assign w_run = (r_mode == MODE_HEX) ? {r_acc, w_dig} : {1'b0, r_acc, w_dig[2:0]};
    assign w_ovf = (w_run[11:8] != 4'd0);

    // Named escape letters.
    always_comb begin
        w_named      = 1'b1;
        w_named_code = CH_NUL;
        case (w_b)
            CH_LO_T:   w_named_code = CH_TAB;
            CH_LO_N:   w_named_code = CH_LF;
            CH_LO_A:   w_named_code = CH_BEL;
            CH_LO_R:   w_named_code = CH_CR;
            CH_LO_F:   w_named_code = CH_FF;
            CH_LO_B:   w_named_code = CH_BS;
            CH_LO_V:   w_named_code = CH_VT;
            CH_BSLASH: w_named_code = CH_BSLASH;
            CH_SQUOTE: w_named_code = CH_SQUOTE;
            CH_DQUOTE: w_named_code = CH_DQUOTE;
            default:   w_named      = 1'b0;
        endcase
    end

    // Character produced by a byte seen in plain mode.
    always_comb begin
        w_plain_has = 1'b1;
        w_plain_ch  = '{code: w_b, bare: 1'b0, ends: 1'b0, nl: 1'b0, status: ST_OK};
        if (w_b == CH_LF) begin
            w_plain_ch = '{code: CH_QMARK, bare: (i_item.quote_char == CH_QMARK),
                           ends: 1'b1, nl: 1'b1, status: ST_NEWLINE};
        end else if (w_b == CH_BSLASH) begin
            w_plain_has = 1'b0;
        end else if (w_b == i_item.quote_char) begin
            w_plain_ch.bare = 1'b1;
            w_plain_ch.ends = 1'b1;
        end
    end

    // Next mode and accumulator.
    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        if (i_item.end_of_input) begin
            n_mode = MODE_PLAIN;
            n_acc  = 8'd0;
        end else begin
            unique case (r_mode)
                MODE_PLAIN: begin
                    n_mode = (w_b == CH_BSLASH) ? MODE_ESC : MODE_PLAIN;
                end
                MODE_ESC: begin
                    n_mode = MODE_PLAIN;
                    if (!w_named && w_oct_ok) begin
                        n_mode = MODE_OCT;
                        n_acc  = {5'd0, w_b[2:0]};
                    end else if (!w_named && (w_b == CH_LO_X)) begin
                        n_mode = MODE_HEX;
                        n_acc  = 8'd0;
                    end
                end
                MODE_OCT, MODE_HEX: begin
                    if (!w_dig_ok || w_ovf) begin
                        n_acc  = 8'd0;
                        n_mode = (w_b == CH_BSLASH) ? MODE_ESC : MODE_PLAIN;
                    end else begin
                        n_acc = w_run[7:0];
                    end
                end
                default: n_mode = MODE_PLAIN;
            endcase
        end
    end

    // Characters finished by this byte.
    always_comb begin
        o_job       = '0;
        o_job.count = 2'd0;
        if (i_item.end_of_input) begin
            o_job.ch0   = '{code: CH_NUL, bare: 1'b1, ends: 1'b1, nl: 1'b0, status: ST_EOF};
            o_job.count = 2'd1;
        end else begin
            unique case (r_mode)
                MODE_PLAIN: begin
                    o_job.ch0   = w_plain_ch;
                    o_job.count = w_plain_has ? 2'd1 : 2'd0;
                end
                MODE_ESC: begin
                    if (w_named) begin
                        o_job.ch0   = '{code: w_named_code, bare: 1'b0, ends: 1'b0,
                                        nl: 1'b0, status: ST_OK};
                        o_job.count = 2'd1;
                    end else if (!w_oct_ok && (w_b != CH_LO_X)) begin
                        o_job.ch0   = '{code: CH_QMARK, bare: 1'b0, ends: 1'b0,
                                        nl: 1'b0, status: ST_UNKNOWN};
                        o_job.count = 2'd1;
                    end
                end
                MODE_OCT, MODE_HEX: begin
                    if (!w_dig_ok || w_ovf) begin
                        o_job.ch0.code = w_dig_ok ? w_run[7:0] : r_acc;
                        o_job.ch0.bare = 1'b0;
                        o_job.ch0.ends = 1'b0;
                        o_job.ch0.nl   = 1'b0;
                        if (!w_dig_ok) begin
                            o_job.ch0.status = ST_OK;
                        end else if (r_mode == MODE_HEX) begin
                            o_job.ch0.status = ST_HEX_OVF;
                        end else begin
                            o_job.ch0.status = ST_OCT_OVF;
                        end
                        // The ending byte is then seen again in plain mode.
                        o_job.ch1   = w_plain_ch;
                        o_job.count = w_plain_has ? 2'd2 : 2'd1;
                    end
                end
                default: o_job.count = 2'd0;
            endcase
        end
    end

    // State registers advance only on an input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
            r_acc  <= 8'd0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
        end
    end

endmodule

// ===== rtl/cle_serial.sv =====
// Result buffer that expands each finished character to its text form, one byte per transfer.
module cle_serial
    import cle_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_job      i_job,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out,
    output logic      o_can_load
);

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } t_form;

    // Canonical text form of one character.
    function automatic t_form form_of(input logic [7:0] code, input logic bare);
        t_form      f;
        logic [7:0] letter;
        letter  = CH_NUL;
        f.len   = 3'd1;
        f.bytes = '0;
        case (code)
            CH_TAB:  letter = CH_LO_T;
            CH_LF:   letter = CH_LO_N;
            CH_CR:   letter = CH_LO_R;
            CH_VT:   letter = CH_LO_V;
            CH_BS:   letter = CH_LO_B;
            CH_FF:   letter = CH_LO_F;
            default: letter = CH_NUL;
        endcase
        if (bare) begin
            f.bytes[0] = code;
        end else if ((code == CH_BSLASH) || (code == CH_SQUOTE) || (code == CH_DQUOTE)) begin
            f.len      = 3'd2;
            f.bytes[0] = CH_BSLASH;
            f.bytes[1] = code;
        end else if ((code >= CH_SPACE) && (code < CH_DEL)) begin
            f.bytes[0] = code;
        end else if (letter != CH_NUL) begin
            f.len      = 3'd2;
            f.bytes[0] = CH_BSLASH;
            f.bytes[1] = letter;
        end else begin
            f.len      = 3'd4;
            f.bytes[0] = CH_BSLASH;
            f.bytes[1] = CH_ZERO | {6'd0, code[7:6]};
            f.bytes[2] = CH_ZERO | {5'd0, code[5:3]};
            f.bytes[3] = CH_ZERO | {5'd0, code[2:0]};
        end
        return f;
    endfunction

    t_char      r_ch0, r_ch1;
    logic [1:0] r_count;
    logic       r_cur;
    logic [1:0] r_idx;

    t_char      w_cur;
    t_form      w_form;
    logic       w_busy;
    logic       w_xfer;
    logic       w_last_byte;
    logic       w_last_char;
    logic       w_done;

    // Current character and its byte position.
    assign w_cur       = r_cur ? r_ch1 : r_ch0;
    assign w_form      = form_of(w_cur.code, w_cur.bare);
    assign w_busy      = (r_count != 2'd0);
    assign w_xfer      = w_busy && !i_out_stall;
    assign w_last_byte = ({1'b0, r_idx} == (w_form.len - 3'd1));
    assign w_last_char = ({1'b0, r_cur} == (r_count - 2'd1));
    assign w_done      = w_xfer && w_last_byte && w_last_char;
    assign o_can_load  = !w_busy || w_done;

    // Result payload comes straight from the buffer registers.
    assign o_out_valid            = w_busy;
    assign o_out.out_byte         = w_form.bytes[r_idx];
    assign o_out.char_code        = w_cur.code;
    assign o_out.last_of_char     = w_last_byte;
    assign o_out.ends_literal     = w_cur.ends;
    assign o_out.newline_returned = w_cur.nl;
    assign o_out.status           = w_cur.status;

    // Character payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ch0 <= i_job.ch0;
            r_ch1 <= i_job.ch1;
        end
    end

    // Buffer occupancy and byte pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_cur   <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_count <= i_job.count;
            r_cur   <= 1'b0;
            r_idx   <= 2'd0;
        end else if (w_done) begin
            r_count <= 2'd0;
        end else if (w_xfer) begin
            if (w_last_byte) begin
                r_cur <= 1'b1;
                r_idx <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

// ===== rtl/char_literal_escape_decoder.sv =====
// Top level of the quoted-literal escape decoder.
//
// Each input transfer carries one raw byte of a literal body (or an end-of-input
// flag) and the quote that ends the literal. The decoder resolves C escapes and
// returns, for each finished character, its code and canonical text form one
// byte per output transfer. An input item is decoded in the cycle it is taken;
// its results (zero to eight bytes) then leave through the result buffer, one
// byte per cycle while the output is not stalled. An item that finishes no
// character (a backslash or a digit inside a run) leaves the buffer empty. The
// next input is taken in the same cycle that the last result byte of the
// previous item transfers, and not before, so the output port sets the rate.
module char_literal_escape_decoder
    import cle_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    logic w_can_load;
    logic w_accept;
    t_job w_job;

    // Input transfer whenever the result buffer is free or emptying now.
    assign o_in_stall = !w_can_load;
    assign w_accept   = i_in_valid && w_can_load;

    cle_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_accept),
        .i_item  (i_in),
        .o_job   (w_job)
    );

    cle_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept),
        .i_job       (w_job),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .o_can_load  (w_can_load)
    );

endmodule
